// File: hdl/ibdv_pkg.sv
// Shared constants, types and the output rounding function for the
// delta-kernel velocity interpolator. No dependencies.
package ibdv_pkg;

  localparam int TILE_N_DEF       = 16;
  localparam int STENCIL_HALF_DEF = 2;

  localparam int VEL_W  = 32;   // Q15.16 velocity
  localparam int POS_W  = 16;   // Q4.12 position
  localparam int FRAC_W = 12;
  localparam int IDX_W  = 4;    // cell index on the load word
  localparam int WT_W   = 17;   // Q1.16 weight
  localparam int ACC_W  = 56;   // exact sum of up to 125 products
  localparam int RND_W  = ACC_W - 16;

  // integer square root of a 34-bit radicand, one result bit per step
  localparam int ROOT_W     = 34;
  localparam int ROOT_STEPS = 17;

  // floor(n/3) = (n * DIV3_MUL) >> DIV3_SHIFT, exact for n < 2^19
  localparam int DIV3_MUL   = 349526;
  localparam int DIV3_SHIFT = 20;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;
  localparam logic KERN_FOUR  = 1'b0;
  localparam logic KERN_THREE = 1'b1;

  typedef logic [WT_W-1:0]         weight_t;
  typedef logic signed [VEL_W-1:0] vel_t;

  typedef struct packed {
    logic [VEL_W-1:0] val;
    logic             sat;
  } rnd_t;

  // round Q.32 sum to Q15.16 (floor of s + half), clamp to 32 bits
  function automatic rnd_t round_sat(input logic signed [ACC_W-1:0] s);
    logic signed [ACC_W-1:0] t;
    logic signed [RND_W-1:0] r;
    logic signed [RND_W-1:0] rmax;
    logic signed [RND_W-1:0] rmin;
    rnd_t o;
    rmax = RND_W'(64'sd2147483647);
    rmin = RND_W'(-64'sd2147483648);
    t = s + ACC_W'(32768);
    r = t[ACC_W-1:16];
    if (r > rmax) begin
      o.val = 32'h7FFF_FFFF;
      o.sat = 1'b1;
    end else if (r < rmin) begin
      o.val = 32'h8000_0000;
      o.sat = 1'b1;
    end else begin
      o.val = r[VEL_W-1:0];
      o.sat = 1'b0;
    end
    return o;
  endfunction

endpackage

// File: hdl/ibdv_if.sv
// Valid/ready channels of the interpolator: input word and result word.
// Depends on ibdv_pkg.
interface ibdv_in_if;
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [ibdv_pkg::IDX_W-1:0]      cell_x;
  logic [ibdv_pkg::IDX_W-1:0]      cell_y;
  logic [ibdv_pkg::IDX_W-1:0]      cell_z;
  ibdv_pkg::vel_t                  vel_u;
  ibdv_pkg::vel_t                  vel_v;
  ibdv_pkg::vel_t                  vel_w;
  logic [ibdv_pkg::POS_W-1:0]      pos_x;
  logic [ibdv_pkg::POS_W-1:0]      pos_y;
  logic [ibdv_pkg::POS_W-1:0]      pos_z;

  modport source (output valid, action, cell_x, cell_y, cell_z, vel_u, vel_v, vel_w,
                  pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, action, cell_x, cell_y, cell_z, vel_u, vel_v, vel_w,
                  pos_x, pos_y, pos_z, output ready);
endinterface

interface ibdv_out_if;
  logic           valid;
  logic           ready;
  ibdv_pkg::vel_t interp_u;
  ibdv_pkg::vel_t interp_v;
  ibdv_pkg::vel_t interp_w;
  logic           saturated;

  modport source (output valid, interp_u, interp_v, interp_w, saturated, input ready);
  modport sink   (input valid, interp_u, interp_v, interp_w, saturated, output ready);
endinterface

// File: hdl/ib_delta_velocity_interpolation_core.sv
// Top level of the immersed-boundary delta-kernel velocity interpolator:
// tile memory, stencil sweep and accumulation. Depends on ibdv_pkg, ibdv_if, ibdv_weight.
//
//  port        dir  word
//  in_i        in   load one cell velocity, or query at a marker position
//  out_o       out  interpolated velocity and saturation flag, one per query
//  cfg_we_i    in   kernel select write (cfg_data_i: 0 four-point, 1 three-point)
//
// A load is written straight into the tile memory and the core stays idle. A query's
// result word is registered once the sweep is through, and the next input word can be
// taken in the cycle after it. The weight units run a 17-step square root per offset,
// then the sweep reads one stencil cell per cycle from the tile memory's single read
// port. Reset needs no memory pass; the tile is undefined until loaded. A result waits
// in the output register; the next query is taken meanwhile and stalls only at its end
// if that register is still full.
module ib_delta_velocity_interpolation_core #(
  parameter int TILE_N       = ibdv_pkg::TILE_N_DEF,
  parameter int STENCIL_HALF = ibdv_pkg::STENCIL_HALF_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  ibdv_in_if.sink     in_i,
  ibdv_out_if.source  out_o
);

  localparam int SPAN  = 2 * STENCIL_HALF + 1;
  localparam int OW    = $clog2(SPAN);
  localparam int CELLS = TILE_N * TILE_N * TILE_N;
  localparam int AW    = $clog2(CELLS);
  localparam int VW    = ibdv_pkg::VEL_W;
  localparam int WW    = ibdv_pkg::WT_W;
  localparam int PW    = VW + WW + 1;
  localparam int AC    = ibdv_pkg::ACC_W;

  typedef enum logic [2:0] {ST_IDLE, ST_WSTART, ST_WGT, ST_ACC, ST_DRAIN, ST_FIN} state_e;

  state_e st_q;
  logic   kernel_q;
  logic   out_vld_q;
  logic [ibdv_pkg::POS_W-1:0] px_q, py_q, pz_q;
  logic [OW-1:0] a_q, b_q, c_q;
  logic [2:0]    tk_q, en_q;

  logic [3*VW-1:0] mem [CELLS];
  logic [3*VW-1:0] rd_q, vel_q;
  logic [WW-1:0]   wxy_q, wz_q, w_q;
  logic signed [PW-1:0] pu_q, pv_q, pw_q;
  logic signed [AC-1:0] su_q, sv_q, sw_q;
  logic [VW-1:0]   ou_q, ov_q, ow_q;
  logic            osat_q;

  ibdv_pkg::weight_t [SPAN-1:0] wx, wy, wz;
  logic bx, by, bz;

  logic in_acc, out_acc, mem_we, load_ok, issue, last, fin_go;
  logic [AW-1:0] waddr, raddr;
  logic signed [7:0] x, y, z;
  logic in_rng;
  ibdv_pkg::rnd_t ru, rv, rw;

  ibdv_weight #(.STENCIL_HALF(STENCIL_HALF)) u_wx (
    .clk_i, .rst_ni, .start_i(st_q == ST_WSTART), .three_i(kernel_q),
    .frac_i(px_q[ibdv_pkg::FRAC_W-1:0]), .busy_o(bx), .wt_o(wx));
  ibdv_weight #(.STENCIL_HALF(STENCIL_HALF)) u_wy (
    .clk_i, .rst_ni, .start_i(st_q == ST_WSTART), .three_i(kernel_q),
    .frac_i(py_q[ibdv_pkg::FRAC_W-1:0]), .busy_o(by), .wt_o(wy));
  ibdv_weight #(.STENCIL_HALF(STENCIL_HALF)) u_wz (
    .clk_i, .rst_ni, .start_i(st_q == ST_WSTART), .three_i(kernel_q),
    .frac_i(pz_q[ibdv_pkg::FRAC_W-1:0]), .busy_o(bz), .wt_o(wz));

  assign in_i.ready = (st_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_vld_q && out_o.ready;

  always_comb begin
    load_ok = (int'(in_i.cell_x) < TILE_N) && (int'(in_i.cell_y) < TILE_N)
              && (int'(in_i.cell_z) < TILE_N);
    mem_we  = in_acc && (in_i.action == ibdv_pkg::ACT_LOAD) && load_ok;
    waddr   = AW'((int'(in_i.cell_z) * TILE_N + int'(in_i.cell_y)) * TILE_N
                  + int'(in_i.cell_x));

    // stencil cell = floor cell - half + offset
    x = 8'({4'h0, px_q[15:12]}) + 8'(a_q) - 8'(STENCIL_HALF);
    y = 8'({4'h0, py_q[15:12]}) + 8'(b_q) - 8'(STENCIL_HALF);
    z = 8'({4'h0, pz_q[15:12]}) + 8'(c_q) - 8'(STENCIL_HALF);
    in_rng = !x[7] && !y[7] && !z[7] && (int'(x) < TILE_N) && (int'(y) < TILE_N)
             && (int'(z) < TILE_N);
    raddr  = AW'((int'(z) * TILE_N + int'(y)) * TILE_N + int'(x));

    issue  = (st_q == ST_ACC);
    last   = (a_q == OW'(SPAN - 1)) && (b_q == OW'(SPAN - 1)) && (c_q == OW'(SPAN - 1));
    fin_go = (st_q == ST_FIN) && (!out_vld_q || out_o.ready);

    ru = ibdv_pkg::round_sat(su_q);
    rv = ibdv_pkg::round_sat(sv_q);
    rw = ibdv_pkg::round_sat(sw_q);
  end

  // tile memory: written only while idle; read every cycle, the data used only during the sweep
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= {in_i.vel_u, in_i.vel_v, in_i.vel_w};
    rd_q <= mem[raddr];
  end

  // sweep datapath: weight product, velocity product, accumulate
  always_ff @(posedge clk_i) begin
    wxy_q <= WW'((34'(wx[a_q]) * 34'(wy[b_q])) >> 16);
    wz_q  <= wz[c_q];
    w_q   <= WW'((34'(wxy_q) * 34'(wz_q)) >> 16);
    vel_q <= rd_q;
    pu_q  <= PW'($signed({1'b0, w_q})) * PW'($signed(vel_q[3*VW-1:2*VW]));
    pv_q  <= PW'($signed({1'b0, w_q})) * PW'($signed(vel_q[2*VW-1:VW]));
    pw_q  <= PW'($signed({1'b0, w_q})) * PW'($signed(vel_q[VW-1:0]));
    if (in_acc) begin
      px_q <= in_i.pos_x;
      py_q <= in_i.pos_y;
      pz_q <= in_i.pos_z;
      su_q <= '0;
      sv_q <= '0;
      sw_q <= '0;
    end else if (tk_q[2] && en_q[2]) begin
      su_q <= su_q + AC'(pu_q);
      sv_q <= sv_q + AC'(pv_q);
      sw_q <= sw_q + AC'(pw_q);
    end
    if (fin_go) begin
      ou_q   <= ru.val;
      ov_q   <= rv.val;
      ow_q   <= rw.val;
      osat_q <= ru.sat | rv.sat | rw.sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      kernel_q  <= ibdv_pkg::KERN_FOUR;
      out_vld_q <= 1'b0;
      a_q       <= '0;
      b_q       <= '0;
      c_q       <= '0;
      tk_q      <= '0;
      en_q      <= '0;
    end else begin
      if (cfg_we_i) kernel_q <= cfg_data_i;
      tk_q <= {tk_q[1:0], issue};
      en_q <= {en_q[1:0], issue && in_rng};
      if (fin_go) out_vld_q <= 1'b1;
      else if (out_acc) out_vld_q <= 1'b0;
      unique case (st_q)
        ST_IDLE: begin
          if (in_acc && in_i.action == ibdv_pkg::ACT_QUERY) st_q <= ST_WSTART;
        end
        ST_WSTART: st_q <= ST_WGT;
        ST_WGT: begin
          a_q <= '0;
          b_q <= '0;
          c_q <= '0;
          if (!bx && !by && !bz) st_q <= ST_ACC;
        end
        ST_ACC: begin
          if (last) begin
            st_q <= ST_DRAIN;
          end else if (c_q == OW'(SPAN - 1)) begin
            c_q <= '0;
            if (b_q == OW'(SPAN - 1)) begin
              b_q <= '0;
              a_q <= a_q + OW'(1);
            end else begin
              b_q <= b_q + OW'(1);
            end
          end else begin
            c_q <= c_q + OW'(1);
          end
        end
        ST_DRAIN: begin
          if (tk_q == 3'b000) st_q <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) st_q <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.interp_u  = ou_q;
  assign out_o.interp_v  = ov_q;
  assign out_o.interp_w  = ow_q;
  assign out_o.saturated = osat_q;

`ifndef SYNTHESIS
  a_we_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> st_q == ST_IDLE) else $error("tile write outside idle");
  a_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_IDLE |-> tk_q == 3'b000) else $error("sweep pipe busy while idle");
  a_en_tok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_q & ~tk_q) == 3'b000) else $error("enable without token");
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(st_q == ST_FIN)) else $error("result not from finish");
`endif

endmodule

// File: hdl/ibdv_weight.sv
// Per-axis kernel weight unit: computes the stencil weights for one axis,
// one offset at a time, with a bit-serial square root. Depends on ibdv_pkg.
module ibdv_weight #(
  parameter int STENCIL_HALF = ibdv_pkg::STENCIL_HALF_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic                                   three_i,
  input  logic [ibdv_pkg::FRAC_W-1:0]            frac_i,
  output logic                                   busy_o,
  output ibdv_pkg::weight_t [2*STENCIL_HALF:0]   wt_o
);

  localparam int SPAN = 2 * STENCIL_HALF + 1;
  localparam int OW   = $clog2(SPAN);
  localparam int RW   = ibdv_pkg::ROOT_W;

  typedef enum logic [2:0] {W_IDLE, W_DIST, W_RAD, W_ROOT, W_DIV} wstate_e;

  wstate_e                     st_q;
  logic [OW-1:0]               o_q;
  logic [4:0]                  it_q;
  logic                        three_q;
  logic [ibdv_pkg::FRAC_W-1:0] frac_q;
  logic [13:0]                 r_q;
  logic                        br0_q, br1_q;
  logic [27:0]                 sq_q;
  logic [RW-1:0]               rem_q, res_q, bit_q;
  ibdv_pkg::weight_t [SPAN-1:0] wt_q;

  // distance to the cell center for the current offset
  logic [15:0]        d;
  logic [13:0]        r_n, dd, sqop;
  logic               br0_n, br1_n;
  logic signed [35:0] rad;
  logic [RW-1:0]      trial;
  logic signed [20:0] num;
  logic [18:0]        n19;
  logic [37:0]        q3;
  logic [20:0]        wt_n;

  always_comb begin
    d     = 16'(frac_q) + 16'(STENCIL_HALF * 4096 - 2048) - 16'({o_q, 12'h000});
    r_n   = d[15] ? 14'(16'd0 - d) : d[13:0];
    br0_n = three_q ? (r_n < 14'd2048) : (r_n < 14'd4096);
    br1_n = three_q ? (r_n < 14'd6144) : (r_n < 14'd8192);
    dd    = (r_n <= 14'd4096) ? (14'd4096 - r_n) : (r_n - 14'd4096);
    sqop  = (three_q && !br0_n) ? dd : r_n;

    if (three_q == ibdv_pkg::KERN_THREE)
      rad = 36'sd16777216 - 36'sd3 * $signed(36'(sq_q));
    else if (br0_q)
      rad = 36'sd16777216 + 36'sd16384 * $signed(36'(r_q)) - 36'sd4 * $signed(36'(sq_q));
    else
      rad = -36'sd117440512 + 36'sd49152 * $signed(36'(r_q)) - 36'sd4 * $signed(36'(sq_q));
    if (rad < 0) rad = '0;

    trial = res_q + bit_q;

    if (three_q == ibdv_pkg::KERN_THREE) begin
      if (br0_q) num = 21'sd65536 + $signed(21'(res_q[16:0]));
      else num = 21'sd327680 - 21'sd48 * $signed(21'(r_q)) - $signed(21'(res_q[16:0]));
    end else begin
      if (br0_q) num = 21'sd196608 - 21'sd32 * $signed(21'(r_q)) + $signed(21'(res_q[16:0]));
      else num = 21'sd327680 - 21'sd32 * $signed(21'(r_q)) - $signed(21'(res_q[16:0]));
    end
    // three-point outer arm divides by 6: halve, then divide by 3
    n19  = br0_q ? num[18:0] : num[19:1];
    q3   = (38'(n19) * 38'(ibdv_pkg::DIV3_MUL)) >> ibdv_pkg::DIV3_SHIFT;
    if (!br1_q || num <= 0) wt_n = '0;
    else if (three_q == ibdv_pkg::KERN_FOUR) wt_n = 21'(num >>> 3);
    else wt_n = q3[20:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= W_IDLE;
      o_q  <= '0;
      it_q <= '0;
    end else begin
      unique case (st_q)
        W_IDLE: begin
          if (start_i) begin
            o_q  <= '0;
            st_q <= W_DIST;
          end
        end
        W_DIST: st_q <= W_RAD;
        W_RAD: begin
          it_q <= '0;
          st_q <= W_ROOT;
        end
        W_ROOT: begin
          it_q <= it_q + 5'd1;
          if (it_q == 5'(ibdv_pkg::ROOT_STEPS - 1)) st_q <= W_DIV;
        end
        W_DIV: begin
          if (o_q == OW'(SPAN - 1)) begin
            st_q <= W_IDLE;
          end else begin
            o_q  <= o_q + OW'(1);
            st_q <= W_DIST;
          end
        end
        default: st_q <= W_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      W_IDLE: begin
        three_q <= three_i;
        frac_q  <= frac_i;
      end
      W_DIST: begin
        r_q   <= r_n;
        br0_q <= br0_n;
        br1_q <= br1_n;
        sq_q  <= 28'(sqop) * 28'(sqop);
      end
      W_RAD: begin
        rem_q <= {rad[25:0], 8'h00};
        res_q <= '0;
        bit_q <= RW'(1) << 32;
      end
      W_ROOT: begin
        if (rem_q >= trial) begin
          rem_q <= rem_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      W_DIV: wt_q[o_q] <= wt_n[ibdv_pkg::WT_W-1:0];
      default: ;
    endcase
  end

  assign busy_o = (st_q != W_IDLE);
  assign wt_o   = wt_q;

endmodule

// File: dv/tb_ib_delta_velocity_interpolation_core.sv
// Self-checking bench for ib_delta_velocity_interpolation_core: loads the tile,
// runs directed and random queries under both kernels, and checks each result.
// Depends on ibdv_pkg, ibdv_if and the core RTL.
module tb_ib_delta_velocity_interpolation_core;

  localparam int TN    = ibdv_pkg::TILE_N_DEF;
  localparam int SH    = ibdv_pkg::STENCIL_HALF_DEF;
  localparam int NCELL = TN * TN * TN;
  localparam int SPAN  = 2 * SH + 1;
  localparam int N_RAND_PER_PHASE = 40;

  typedef struct packed {
    logic        action;
    logic [3:0]  cx, cy, cz;
    logic [31:0] vu, vv, vw;
    logic [15:0] px, py, pz;
  } word_t;

  typedef struct packed {
    logic [31:0] u, v, w;
    logic        sat;
  } interp_t;

  typedef struct packed {
    logic    typed;
    interp_t res;
  } meta_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_data_i = 1'b0;

  ibdv_in_if  in_if ();
  ibdv_out_if out_if ();

  ib_delta_velocity_interpolation_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #4 clk_i = ~clk_i;

  // shadow state of the block
  logic [31:0] tile_u [NCELL];
  logic [31:0] tile_v [NCELL];
  logic [31:0] tile_w [NCELL];
  logic        kern_sel = ibdv_pkg::KERN_FOUR;

  interp_t interp_q[$];
  meta_t   meta_q[$];

  int n_fail = 0, n_load = 0, n_query = 0, n_res = 0, n_sat = 0;
  bit hold_off = 1'b0;
  bit burst_on = 1'b0;
  int burst_left = 0;

  function automatic longint int_sqrt(longint v);
    longint res, bitv;
    res = 0;
    bitv = longint'(1) << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Q1.16 kernel weight at distance rq (Q4.12)
  function automatic longint delta_wt(longint rq, logic three);
    longint a, s, num, d;
    if (three == ibdv_pkg::KERN_FOUR) begin
      if (rq < 4096) begin
        a = 16777216 + 16384 * rq - 4 * rq * rq;
        s = int_sqrt(a << 8);
        num = 3 * 65536 - 32 * rq + s;
        return (num > 0) ? num / 8 : 0;
      end
      if (rq < 8192) begin
        a = -7 * 16777216 + 3 * 16384 * rq - 4 * rq * rq;
        if (a < 0) a = 0;
        s = int_sqrt(a << 8);
        num = 5 * 65536 - 32 * rq - s;
        return (num > 0) ? num / 8 : 0;
      end
      return 0;
    end
    if (rq < 2048) begin
      a = 16777216 - 3 * rq * rq;
      s = int_sqrt(a << 8);
      return (65536 + s) / 3;
    end
    if (rq < 6144) begin
      d = 4096 - rq;
      a = 16777216 - 3 * d * d;
      if (a < 0) a = 0;
      s = int_sqrt(a << 8);
      num = 5 * 65536 - 48 * rq - s;
      return (num > 0) ? num / 6 : 0;
    end
    return 0;
  endfunction

  function automatic void clamp_sum(input longint s, output logic [31:0] val,
                                    inout logic sat);
    longint r;
    r = (s + 32768) >>> 16;
    if (r > 64'sd2147483647) begin
      val = 32'h7FFF_FFFF;
      sat = 1'b1;
    end else if (r < -64'sd2147483648) begin
      val = 32'h8000_0000;
      sat = 1'b1;
    end else begin
      val = r[31:0];
    end
  endfunction

  function automatic interp_t interp_at(logic [15:0] px, logic [15:0] py, logic [15:0] pz);
    longint wx[SPAN], wy[SPAN], wz[SPAN];
    int bx, by, bz, x, y, z, idx;
    longint su, sv, sw, wxy, wc, d;
    interp_t r;
    su = 0; sv = 0; sw = 0;
    bx = int'(px >> 12) - SH;
    by = int'(py >> 12) - SH;
    bz = int'(pz >> 12) - SH;
    for (int o = 0; o < SPAN; o++) begin
      d = longint'(px) - longint'(bx + o) * 4096 - 2048;
      wx[o] = delta_wt(d < 0 ? -d : d, kern_sel);
      d = longint'(py) - longint'(by + o) * 4096 - 2048;
      wy[o] = delta_wt(d < 0 ? -d : d, kern_sel);
      d = longint'(pz) - longint'(bz + o) * 4096 - 2048;
      wz[o] = delta_wt(d < 0 ? -d : d, kern_sel);
    end
    for (int a = 0; a < SPAN; a++) begin
      x = bx + a;
      if (x < 0 || x >= TN) continue;
      for (int b = 0; b < SPAN; b++) begin
        y = by + b;
        if (y < 0 || y >= TN) continue;
        wxy = (wx[a] * wy[b]) / 65536;
        for (int c = 0; c < SPAN; c++) begin
          z = bz + c;
          if (z < 0 || z >= TN) continue;
          wc = (wxy * wz[c]) / 65536;
          idx = (z * TN + y) * TN + x;
          su += wc * longint'($signed(tile_u[idx]));
          sv += wc * longint'($signed(tile_v[idx]));
          sw += wc * longint'($signed(tile_w[idx]));
        end
      end
    end
    r.sat = 1'b0;
    clamp_sum(su, r.u, r.sat);
    clamp_sum(sv, r.v, r.sat);
    clamp_sum(sw, r.w, r.sat);
    return r;
  endfunction

  // input side: update shadow tile or queue the expected result
  always @(posedge clk_i) begin
    meta_t m;
    int idx;
    if (rst_ni && in_if.valid && in_if.ready) begin
      m = meta_q.pop_front();
      if (in_if.action == ibdv_pkg::ACT_LOAD) begin
        idx = (int'(in_if.cell_z) * TN + int'(in_if.cell_y)) * TN + int'(in_if.cell_x);
        tile_u[idx] = in_if.vel_u;
        tile_v[idx] = in_if.vel_v;
        tile_w[idx] = in_if.vel_w;
        n_load++;
      end else begin
        n_query++;
        if (m.typed) interp_q = {interp_q, m.res};
        else interp_q = {interp_q, interp_at(in_if.pos_x, in_if.pos_y, in_if.pos_z)};
      end
    end
  end

  // output side
  always @(posedge clk_i) begin
    interp_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_res++;
      if (out_if.saturated) n_sat++;
      if (interp_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("ERROR: result word with nothing expected");
      end else begin
        e = interp_q.pop_front();
        if (out_if.interp_u !== e.u || out_if.interp_v !== e.v ||
            out_if.interp_w !== e.w || out_if.saturated !== e.sat) begin
          n_fail++;
          if (n_fail <= 10)
            $display("ERROR: exp u=%h v=%h w=%h sat=%b got u=%h v=%h w=%h sat=%b",
                     e.u, e.v, e.w, e.sat, out_if.interp_u, out_if.interp_v,
                     out_if.interp_w, out_if.saturated);
        end
      end
    end
  end

  // receiver stall pattern; long hold-off overrides it
  always @(posedge clk_i) begin
    int phase_cnt;
    phase_cnt = int'(($time / 8) % 1200);
    if (!rst_ni) out_if.ready <= 1'b0;
    else if (hold_off) out_if.ready <= 1'b0;
    else if (phase_cnt < 400) out_if.ready <= 1'b1;
    else out_if.ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_word(word_t wd, meta_t m);
    int gap;
    if (burst_left == 0) begin
      gap = int'($urandom_range(0, 6));
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = int'($urandom_range(1, 12));
    end
    meta_q = {meta_q, m};
    in_if.valid  <= 1'b1;
    in_if.action <= wd.action;
    in_if.cell_x <= wd.cx;
    in_if.cell_y <= wd.cy;
    in_if.cell_z <= wd.cz;
    in_if.vel_u  <= wd.vu;
    in_if.vel_v  <= wd.vv;
    in_if.vel_w  <= wd.vw;
    in_if.pos_x  <= wd.px;
    in_if.pos_y  <= wd.py;
    in_if.pos_z  <= wd.pz;
    do @(posedge clk_i); while (!in_if.ready);
    burst_left--;
  endtask

  task automatic drain_and_set_kernel(logic k);
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (interp_q.size() != 0 || meta_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= k;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    kern_sel = k;
  endtask

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  // positions stay in the low corner box (floor 0..2) or the high one (floor 13..15)
  function automatic logic [15:0] rand_pos(logic hi);
    case ($urandom_range(0, 3))
      0: return hi ? 16'hFFFF : 16'h0000;
      1: return hi ? 16'hD000 : 16'h2FFF;
      2: return {hi ? 4'(13 + $urandom_range(0, 2)) : 4'($urandom_range(0, 2)), 12'h800};
      default: return hi ? 16'(16'hD000 + $urandom_range(0, 16'h2FFF))
                         : 16'($urandom_range(0, 16'h2FFF));
    endcase
  endfunction

  // directed words; only the first query has its result typed in (its corner box still all zero)
  localparam int N_DIR = 20;
  word_t stim_tab [N_DIR] = '{
    '{ibdv_pkg::ACT_QUERY, 4'd0, 4'd0, 4'd0, 32'h0, 32'h0, 32'h0,
      16'h2800, 16'h2800, 16'h2800},
    '{ibdv_pkg::ACT_LOAD, 4'd0, 4'd0, 4'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
      16'h0, 16'h0, 16'h0},
    '{ibdv_pkg::ACT_LOAD, 4'd15, 4'd15, 4'd15, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000,
      16'h0, 16'h0, 16'h0},
    '{ibdv_pkg::ACT_LOAD, 4'd2, 4'd2, 4'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
      16'h0, 16'h0, 16'h0},
    '{ibdv_pkg::ACT_LOAD, 4'd3, 4'd2, 4'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
      16'h0, 16'h0, 16'h0},
    '{ibdv_pkg::ACT_LOAD, 4'd2, 4'd3, 4'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
      16'h0, 16'h0, 16'h0},
    '{ibdv_pkg::ACT_LOAD, 4'd2, 4'd2, 4'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
      16'h0, 16'h0, 16'h0},
    '{ibdv_pkg::ACT_LOAD, 4'd1, 4'd0, 4'd0, 32'h0002_8000, 32'hFFFD_0000, 32'h1234_5678,
      16'h0, 16'h0, 16'h0},
    '{ibdv_pkg::ACT_QUERY, 4'd0, 4'd0, 4'd0, 32'h0, 32'h0, 32'h0,
      16'h0000, 16'h0000, 16'h0000},
    '{ibdv_pkg::ACT_QUERY, 4'd0, 4'd0, 4'd0, 32'h0, 32'h0, 32'h0,
      16'hFFFF, 16'hFFFF, 16'hFFFF},
    '{ibdv_pkg::ACT_QUERY, 4'd0, 4'd0, 4'd0, 32'h0, 32'h0, 32'h0,
      16'h0800, 16'h0800, 16'h0800},
    '{ibdv_pkg::ACT_QUERY, 4'd0, 4'd0, 4'd0, 32'h0, 32'h0, 32'h0,
      16'h2800, 16'h2800, 16'h2800},
    '{ibdv_pkg::ACT_QUERY, 4'd0, 4'd0, 4'd0, 32'h0, 32'h0, 32'h0,
      16'h2000, 16'h2000, 16'h2000},
    '{ibdv_pkg::ACT_QUERY, 4'd0, 4'd0, 4'd0, 32'h0, 32'h0, 32'h0,
      16'h2000, 16'h2C00, 16'h2400},
    '{ibdv_pkg::ACT_QUERY, 4'd0, 4'd0, 4'd0, 32'h0, 32'h0, 32'h0,
      16'h2001, 16'h1FFF, 16'h2400},
    '{ibdv_pkg::ACT_QUERY, 4'd0, 4'd0, 4'd0, 32'h0, 32'h0, 32'h0,
      16'h1000, 16'h0000, 16'h0FFF},
    '{ibdv_pkg::ACT_QUERY, 4'd0, 4'd0, 4'd0, 32'h0, 32'h0, 32'h0,
      16'hF000, 16'hE800, 16'hF800},
    '{ibdv_pkg::ACT_QUERY, 4'd0, 4'd0, 4'd0, 32'h0, 32'h0, 32'h0,
      16'h2FFF, 16'h2001, 16'h2800},
    '{ibdv_pkg::ACT_QUERY, 4'd0, 4'd0, 4'd0, 32'h0, 32'h0, 32'h0,
      16'hD800, 16'hE000, 16'hD000},
    '{ibdv_pkg::ACT_QUERY, 4'd0, 4'd0, 4'd0, 32'h0, 32'h0, 32'h0,
      16'hD000, 16'hFFFE, 16'hE800}
  };

  // long receiver hold-off once the random part is running
  initial begin
    int held;
    wait (burst_on);
    repeat (600) @(posedge clk_i);
    hold_off = 1'b1;
    held = 0;
    while (held < 2500) begin
      @(posedge clk_i);
      held++;
    end
    hold_off = 1'b0;
  end

  initial begin
    word_t wd;
    meta_t m;
    logic k;
    logic hi;
    in_if.valid  <= 1'b0;
    in_if.action <= ibdv_pkg::ACT_LOAD;
    in_if.cell_x <= '0; in_if.cell_y <= '0; in_if.cell_z <= '0;
    in_if.vel_u  <= '0; in_if.vel_v  <= '0; in_if.vel_w  <= '0;
    in_if.pos_x  <= '0; in_if.pos_y  <= '0; in_if.pos_z  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero the two 5x5x5 corner boxes; every query stencil stays inside one of them
    m = '0;
    for (int hb = 0; hb < 2; hb++) begin
      for (int i = 0; i < 125; i++) begin
        wd = '0;
        wd.action = ibdv_pkg::ACT_LOAD;
        wd.cx = 4'(hb * 11 + i % 5);
        wd.cy = 4'(hb * 11 + (i / 5) % 5);
        wd.cz = 4'(hb * 11 + i / 25);
        send_word(wd, m);
      end
    end

    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) drain_and_set_kernel(ibdv_pkg::KERN_THREE);
      for (int r = 0; r < N_DIR; r++) begin
        m = '0;
        m.typed = (pass == 0 && r == 0);
        send_word(stim_tab[r], m);
      end
    end

    burst_on = 1'b1;
    for (int ph = 0; ph < 3; ph++) begin
      k = (ph == 1) ? ibdv_pkg::KERN_THREE : ibdv_pkg::KERN_FOUR;
      drain_and_set_kernel(k);
      for (int n = 0; n < N_RAND_PER_PHASE; n++) begin
        hi = ($urandom_range(0, 1) == 1);
        wd.action = ($urandom_range(0, 1) == 0) ? ibdv_pkg::ACT_LOAD : ibdv_pkg::ACT_QUERY;
        wd.cx = 4'($urandom); wd.cy = 4'($urandom); wd.cz = 4'($urandom);
        wd.vu = rand_vel(); wd.vv = rand_vel(); wd.vw = rand_vel();
        wd.px = rand_pos(hi); wd.py = rand_pos(hi); wd.pz = rand_pos(hi);
        // cluster of max loads near a query point to push toward clamping
        if (wd.action == ibdv_pkg::ACT_LOAD && $urandom_range(0, 3) == 0) begin
          wd.cx = 4'(12 + $urandom_range(0, 2));
          wd.cy = 4'(12 + $urandom_range(0, 2));
          wd.cz = 4'(12 + $urandom_range(0, 2));
          wd.vu = 32'h7FFF_FFFF; wd.vv = 32'h8000_0000;
        end else if (wd.action == ibdv_pkg::ACT_QUERY && $urandom_range(0, 5) == 0) begin
          wd.px = 16'(16'hD000 + $urandom_range(0, 16'h0FFF));
          wd.py = 16'(16'hD000 + $urandom_range(0, 16'h0FFF));
          wd.pz = 16'(16'hD000 + $urandom_range(0, 16'h0FFF));
        end
        send_word(wd, '0);
      end
    end
    in_if.valid <= 1'b0;

    while (interp_q.size() != 0 || meta_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("Covered %0d loads and %0d queries over both kernels; %0d results, %0d clamped.",
             n_load, n_query, n_res, n_sat);
    if (n_fail == 0) begin
      $display("** ib_delta_velocity_interpolation_core: PASSED **");
    end else begin
      $display("%0d mismatches", n_fail);
      $display("** ib_delta_velocity_interpolation_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #16000000;
    $display("Timeout with %0d results outstanding", interp_q.size());
    $display("** ib_delta_velocity_interpolation_core: FAILED **");
    $finish;
  end

endmodule

// File: files.f
hdl/ibdv_pkg.sv
hdl/ibdv_if.sv
hdl/ibdv_weight.sv
hdl/ib_delta_velocity_interpolation_core.sv
dv/tb_ib_delta_velocity_interpolation_core.sv
